// ===== design/rqi_pkg.sv =====
package rqi_pkg;

    // Number formats: vectors carry three signed Q11.10 components, scalars are Q16.16.
    localparam int COORD_BITS  = 21;
    localparam int SCALAR_BITS = 32;
    localparam int COORD_FRAC  = 10;
    localparam int SCALAR_FRAC = 16;
    localparam int MAT_W       = 8;
    localparam int IDX_W       = 3;

    // Derived widths of the datapath.
    localparam int VEC_W     = 3 * COORD_BITS;
    localparam int PROD_W    = 2 * COORD_BITS;
    localparam int DOT_W     = PROD_W + 2;
    localparam int NUM_W     = DOT_W + 1;
    localparam int QUO_W     = SCALAR_BITS;
    localparam int REM_W     = DOT_W + 1;
    localparam int DIV_PRE   = QUO_W - SCALAR_FRAC;
    localparam int PRE_W     = DOT_W + DIV_PRE;
    localparam int OFS_SHIFT = 2 * COORD_FRAC - SCALAR_FRAC;
    localparam int MUL_W     = SCALAR_BITS + COORD_BITS;
    localparam int PT_W      = MUL_W - SCALAR_FRAC + 1;
    localparam int PQ_W      = COORD_BITS + 1;
    localparam int CP_W      = 2 * PQ_W;
    localparam int CR_W      = CP_W + 1;
    localparam int WC_W      = COORD_BITS + CR_W;
    localparam int PL_W      = WC_W + 2;
    localparam int UV_W      = SCALAR_FRAC + 1;
    localparam int UV_SHIFT  = 3 * COORD_FRAC - SCALAR_FRAC;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_CORNER,
        REG_EDGE_U,
        REG_EDGE_V,
        REG_SCALED_N,
        REG_NORMAL,
        REG_OFFSET,
        REG_MATERIAL
    } cfg_index_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [VEC_W-1:0]              corner;
        logic [VEC_W-1:0]              edge_u;
        logic [VEC_W-1:0]              edge_v;
        logic [VEC_W-1:0]              scaled_n;
        logic [VEC_W-1:0]              normal;
        logic signed [SCALAR_BITS-1:0] offset;
        logic [MAT_W-1:0]              material;
    } cfg_t;

    typedef struct packed {
        logic [VEC_W-1:0]              ray_origin;
        logic [VEC_W-1:0]              ray_direction;
        logic signed [SCALAR_BITS-1:0] t_min;
        logic signed [SCALAR_BITS-1:0] t_max;
    } ray_t;

    // Plane distance split into sign and magnitudes, ready for the divider.
    typedef struct packed {
        ray_t             ray;
        logic             neg;
        logic             front_face;
        logic             parallel;
        logic [NUM_W-1:0] un;
        logic [DOT_W-1:0] ud;
    } front_t;

    typedef struct packed {
        ray_t             ray;
        logic             neg;
        logic             front_face;
        logic             miss;
        logic [QUO_W-1:0] quo;
    } div_t;

    typedef struct packed {
        logic                          hit;
        logic signed [SCALAR_BITS-1:0] hit_t;
        logic [VEC_W-1:0]              hit_point;
        logic [VEC_W-1:0]              hit_normal;
        logic [UV_W-1:0]               surface_u;
        logic [UV_W-1:0]               surface_v;
        logic                          front_face;
        logic [MAT_W-1:0]              hit_material;
    } result_t;

    // Pick one signed component out of a packed vector word.
    function automatic coord_t comp(input logic [VEC_W-1:0] v, input int i);
        return v[i*COORD_BITS +: COORD_BITS];
    endfunction

endpackage

// ===== design/rqi_channels.sv =====
interface rqi_ray_if;
    logic                                   valid;
    logic                                   ready;
    logic [rqi_pkg::VEC_W-1:0]              ray_origin;
    logic [rqi_pkg::VEC_W-1:0]              ray_direction;
    logic signed [rqi_pkg::SCALAR_BITS-1:0] t_min;
    logic signed [rqi_pkg::SCALAR_BITS-1:0] t_max;

    modport source (output valid, ray_origin, ray_direction, t_min, t_max, input ready);
    modport sink (input valid, ray_origin, ray_direction, t_min, t_max, output ready);
endinterface

interface rqi_hit_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   hit;
    logic signed [rqi_pkg::SCALAR_BITS-1:0] hit_t;
    logic [rqi_pkg::VEC_W-1:0]              hit_point;
    logic [rqi_pkg::VEC_W-1:0]              hit_normal;
    logic [rqi_pkg::UV_W-1:0]               surface_u;
    logic [rqi_pkg::UV_W-1:0]               surface_v;
    logic                                   front_face;
    logic [rqi_pkg::MAT_W-1:0]              hit_material;

    modport source (output valid, hit, hit_t, hit_point, hit_normal, surface_u, surface_v,
                    front_face, hit_material, input ready);
    modport sink (input valid, hit, hit_t, hit_point, hit_normal, surface_u, surface_v,
                  front_face, hit_material, output ready);
endinterface

// ===== design/rqi_front.sv =====
module rqi_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rqi_pkg::ray_t   in_ray,
    input  rqi_pkg::cfg_t   cfg,
    output logic            out_valid,
    output rqi_pkg::front_t out_data
);

    typedef logic signed [rqi_pkg::PROD_W-1:0] prod_t;

    logic            s1_valid_reg;
    logic            s2_valid_reg;
    rqi_pkg::ray_t   s1_ray_reg;
    prod_t           nd_reg [3];
    prod_t           nd_next [3];
    prod_t           no_reg [3];
    prod_t           no_next [3];
    rqi_pkg::front_t s2_reg;
    rqi_pkg::front_t s2_next;

    logic signed [rqi_pkg::DOT_W-1:0] den;
    logic signed [rqi_pkg::DOT_W-1:0] dot_o;
    logic signed [rqi_pkg::NUM_W-1:0] num;

    // Stage one: the six component products of the normal with direction and origin.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nd_next[i] = rqi_pkg::PROD_W'(rqi_pkg::comp(cfg.normal, i))
                       * rqi_pkg::PROD_W'(rqi_pkg::comp(in_ray.ray_direction, i));
            no_next[i] = rqi_pkg::PROD_W'(rqi_pkg::comp(cfg.normal, i))
                       * rqi_pkg::PROD_W'(rqi_pkg::comp(in_ray.ray_origin, i));
        end
    end

    // Stage two: sum into the denominator and numerator, then split sign and magnitude.
    always_comb
    begin
        den = rqi_pkg::DOT_W'(nd_reg[0]) + rqi_pkg::DOT_W'(nd_reg[1])
            + rqi_pkg::DOT_W'(nd_reg[2]);
        dot_o = rqi_pkg::DOT_W'(no_reg[0]) + rqi_pkg::DOT_W'(no_reg[1])
              + rqi_pkg::DOT_W'(no_reg[2]);
        num = (rqi_pkg::NUM_W'(cfg.offset) <<< rqi_pkg::OFS_SHIFT)
            - rqi_pkg::NUM_W'(dot_o);
        s2_next.ray        = s1_ray_reg;
        s2_next.neg        = num[rqi_pkg::NUM_W-1] != den[rqi_pkg::DOT_W-1];
        s2_next.front_face = den[rqi_pkg::DOT_W-1];
        s2_next.parallel   = den == '0;
        s2_next.un         = num[rqi_pkg::NUM_W-1] ? -num : num;
        s2_next.ud         = den[rqi_pkg::DOT_W-1] ? -den : den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ray_reg <= in_ray;
            nd_reg     <= nd_next;
            no_reg     <= no_next;
            s2_reg     <= s2_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

endmodule

// ===== design/rqi_div.sv =====
module rqi_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  rqi_pkg::front_t in_data,
    output logic            out_valid,
    output rqi_pkg::div_t   out_data
);

    typedef struct packed {
        rqi_pkg::front_t              f;
        logic                         miss;
        logic [rqi_pkg::REM_W-1:0]    rem;
        logic [rqi_pkg::QUO_W-1:0]    quo;
    } dstage_t;

    logic [rqi_pkg::QUO_W:0] vld_reg;
    logic [rqi_pkg::QUO_W:0] vld_next;
    dstage_t                 st_reg [rqi_pkg::QUO_W+1];
    dstage_t                 st_next [rqi_pkg::QUO_W+1];

    logic                      ovf;
    logic [rqi_pkg::QUO_W-1:0] feed;
    logic [rqi_pkg::REM_W-1:0] sh;
    logic [rqi_pkg::REM_W-1:0] dvs;
    logic                      ge;

    // Entry stage: a quotient that needs more than QUO_W bits is an overflow.
    always_comb
    begin
        ovf = rqi_pkg::PRE_W'(in_data.un) >= {in_data.ud, {rqi_pkg::DIV_PRE{1'b0}}};
        st_next[0].f    = in_data;
        st_next[0].miss = in_data.parallel || ovf;
        st_next[0].rem  = rqi_pkg::REM_W'(in_data.un >> rqi_pkg::DIV_PRE);
        st_next[0].quo  = '0;
    end

    // One restoring step per stage, most significant quotient bit first.
    always_comb
    begin
        feed = '0;
        sh   = '0;
        dvs  = '0;
        ge   = 1'b0;
        for (int k = 0; k < rqi_pkg::QUO_W; k++)
        begin
            feed = rqi_pkg::QUO_W'({st_reg[k].f.un, {rqi_pkg::SCALAR_FRAC{1'b0}}});
            sh   = {st_reg[k].rem[rqi_pkg::REM_W-2:0], feed[rqi_pkg::QUO_W-1-k]};
            dvs  = rqi_pkg::REM_W'(st_reg[k].f.ud);
            ge   = sh >= dvs;
            st_next[k+1]     = st_reg[k];
            st_next[k+1].rem = ge ? sh - dvs : sh;
            st_next[k+1].quo = {st_reg[k].quo[rqi_pkg::QUO_W-2:0], ge};
        end
    end

    assign vld_next = {vld_reg[rqi_pkg::QUO_W-1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign out_valid           = vld_reg[rqi_pkg::QUO_W];
    assign out_data.ray        = st_reg[rqi_pkg::QUO_W].f.ray;
    assign out_data.neg        = st_reg[rqi_pkg::QUO_W].f.neg;
    assign out_data.front_face = st_reg[rqi_pkg::QUO_W].f.front_face;
    assign out_data.miss       = st_reg[rqi_pkg::QUO_W].miss;
    assign out_data.quo        = st_reg[rqi_pkg::QUO_W].quo;

endmodule

// ===== design/rqi_back.sv =====
module rqi_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  rqi_pkg::div_t    in_data,
    input  rqi_pkg::cfg_t    cfg,
    output logic             out_valid,
    output rqi_pkg::result_t out_data
);

    typedef logic signed [rqi_pkg::SCALAR_BITS-1:0] scal_t;
    typedef logic signed [rqi_pkg::MUL_W-1:0]       mul_t;
    typedef logic signed [rqi_pkg::PQ_W-1:0]        pq_t;
    typedef logic signed [rqi_pkg::CP_W-1:0]        cp_t;
    typedef logic signed [rqi_pkg::CR_W-1:0]        cr_t;
    typedef logic signed [rqi_pkg::WC_W-1:0]        wc_t;
    typedef logic signed [rqi_pkg::PL_W-1:0]        pl_t;
    typedef logic signed [rqi_pkg::PT_W-1:0]        pt_t;

    localparam pl_t ONE_PLANAR = rqi_pkg::PL_W'(1) <<< (3 * rqi_pkg::COORD_FRAC);

    logic [5:0] vld_reg;

    // Per-stage payload that rides along.
    logic                      miss_reg [6];
    logic                      miss_next [6];
    logic                      ff_reg [6];
    scal_t                     t_reg [6];
    rqi_pkg::ray_t             ray_reg [2];
    scal_t                     t_next;
    mul_t                      tm_reg [3];
    mul_t                      tm_next [3];
    logic [rqi_pkg::VEC_W-1:0] p_reg [4];
    logic [rqi_pkg::VEC_W-1:0] p_next;
    pq_t                       pq_reg [3];
    pq_t                       pq_next [3];
    cp_t                       ap_reg [3];
    cp_t                       ap_next [3];
    cp_t                       an_reg [3];
    cp_t                       an_next [3];
    cp_t                       bp_reg [3];
    cp_t                       bp_next [3];
    cp_t                       bn_reg [3];
    cp_t                       bn_next [3];
    wc_t                       wa_reg [3];
    wc_t                       wa_next [3];
    wc_t                       wb_reg [3];
    wc_t                       wb_next [3];
    rqi_pkg::result_t          res_reg;
    rqi_pkg::result_t          res_next;

    logic [rqi_pkg::QUO_W-1:0] lim;
    pt_t                       pfull;
    rqi_pkg::coord_t           pc;
    pq_t                       ua [3];
    pq_t                       va [3];
    int                        i1;
    int                        i2;
    pl_t                       sa;
    pl_t                       sb;
    logic                      ok_a;
    logic                      ok_b;
    rqi_pkg::coord_t           nc;
    logic [rqi_pkg::VEC_W-1:0] nn;

    // Stage one: range of the quotient, signed t and the interval test.
    always_comb
    begin
        lim = (rqi_pkg::QUO_W'(1) << (rqi_pkg::SCALAR_BITS - 1))
            - rqi_pkg::QUO_W'(!in_data.neg);
        t_next = in_data.neg ? rqi_pkg::SCALAR_BITS'(0 - in_data.quo)
                             : rqi_pkg::SCALAR_BITS'(in_data.quo);
        miss_next[0] = in_data.miss || (in_data.quo > lim)
                    || (t_next < in_data.ray.t_min) || (t_next > in_data.ray.t_max);
    end

    // Stage two: t times each direction component.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tm_next[i] = rqi_pkg::MUL_W'(t_reg[0])
                       * rqi_pkg::MUL_W'(rqi_pkg::comp(ray_reg[0].ray_direction, i));
        end
        miss_next[1] = miss_reg[0];
    end

    // Stage three: hit point rounded down, its range check, and offset from the corner.
    always_comb
    begin
        miss_next[2] = miss_reg[1];
        p_next = '0;
        pfull  = '0;
        pc     = '0;
        for (int i = 0; i < 3; i++)
        begin
            pfull = rqi_pkg::PT_W'(rqi_pkg::comp(ray_reg[1].ray_origin, i))
                  + rqi_pkg::PT_W'(tm_reg[i] >>> rqi_pkg::SCALAR_FRAC);
            pc    = pfull[rqi_pkg::COORD_BITS-1:0];
            if (rqi_pkg::PT_W'(pc) != pfull)
            begin
                miss_next[2] = 1'b1;
            end
            p_next[i*rqi_pkg::COORD_BITS +: rqi_pkg::COORD_BITS] = pc;
            pq_next[i] = rqi_pkg::PQ_W'(pc) - rqi_pkg::PQ_W'(rqi_pkg::comp(cfg.corner, i));
        end
    end

    // Stage four: the cross product terms for both planar coordinates.
    always_comb
    begin
        i1 = 0;
        i2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            ua[i] = rqi_pkg::PQ_W'(rqi_pkg::comp(cfg.edge_u, i));
            va[i] = rqi_pkg::PQ_W'(rqi_pkg::comp(cfg.edge_v, i));
        end
        for (int i = 0; i < 3; i++)
        begin
            i1 = (i == 2) ? 0 : i + 1;
            i2 = (i == 0) ? 2 : i - 1;
            ap_next[i] = rqi_pkg::CP_W'(pq_reg[i1]) * rqi_pkg::CP_W'(va[i2]);
            an_next[i] = rqi_pkg::CP_W'(pq_reg[i2]) * rqi_pkg::CP_W'(va[i1]);
            bp_next[i] = rqi_pkg::CP_W'(ua[i1]) * rqi_pkg::CP_W'(pq_reg[i2]);
            bn_next[i] = rqi_pkg::CP_W'(ua[i2]) * rqi_pkg::CP_W'(pq_reg[i1]);
        end
        miss_next[3] = miss_reg[2];
    end

    // Stage five: finish the cross products and weight them by the scaled normal.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wa_next[i] = rqi_pkg::WC_W'(rqi_pkg::comp(cfg.scaled_n, i))
                       * rqi_pkg::WC_W'(cr_t'(rqi_pkg::CR_W'(ap_reg[i])
                                             - rqi_pkg::CR_W'(an_reg[i])));
            wb_next[i] = rqi_pkg::WC_W'(rqi_pkg::comp(cfg.scaled_n, i))
                       * rqi_pkg::WC_W'(cr_t'(rqi_pkg::CR_W'(bp_reg[i])
                                             - rqi_pkg::CR_W'(bn_reg[i])));
        end
        miss_next[4] = miss_reg[3];
    end

    // Stage six: planar coordinates in the unit square, normal facing the ray, result word.
    always_comb
    begin
        sa = rqi_pkg::PL_W'(wa_reg[0]) + rqi_pkg::PL_W'(wa_reg[1])
           + rqi_pkg::PL_W'(wa_reg[2]);
        sb = rqi_pkg::PL_W'(wb_reg[0]) + rqi_pkg::PL_W'(wb_reg[1])
           + rqi_pkg::PL_W'(wb_reg[2]);
        ok_a = !sa[rqi_pkg::PL_W-1] && (sa <= ONE_PLANAR);
        ok_b = !sb[rqi_pkg::PL_W-1] && (sb <= ONE_PLANAR);
        nn = '0;
        nc = '0;
        for (int i = 0; i < 3; i++)
        begin
            nc = rqi_pkg::comp(cfg.normal, i);
            if (!ff_reg[4])
            begin
                nc = (nc == {1'b1, {(rqi_pkg::COORD_BITS-1){1'b0}}})
                   ? {1'b0, {(rqi_pkg::COORD_BITS-1){1'b1}}} : -nc;
            end
            nn[i*rqi_pkg::COORD_BITS +: rqi_pkg::COORD_BITS] = nc;
        end
        miss_next[5] = miss_reg[4] || !ok_a || !ok_b;
        res_next = '0;
        if (!miss_next[5])
        begin
            res_next.hit          = 1'b1;
            res_next.hit_t        = t_reg[4];
            res_next.hit_point    = p_reg[3];
            res_next.hit_normal   = nn;
            res_next.surface_u    = rqi_pkg::UV_W'(sa >>> rqi_pkg::UV_SHIFT);
            res_next.surface_v    = rqi_pkg::UV_W'(sb >>> rqi_pkg::UV_SHIFT);
            res_next.front_face   = ff_reg[4];
            res_next.hit_material = cfg.material;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            miss_reg   <= miss_next;
            ff_reg[0]  <= in_data.front_face;
            t_reg[0]   <= t_next;
            ray_reg[0] <= in_data.ray;
            ray_reg[1] <= ray_reg[0];
            for (int s = 1; s < 6; s++)
            begin
                ff_reg[s] <= ff_reg[s-1];
                t_reg[s]  <= t_reg[s-1];
            end
            tm_reg   <= tm_next;
            p_reg[0] <= '0;
            p_reg[1] <= p_next;
            p_reg[2] <= p_reg[1];
            p_reg[3] <= p_reg[2];
            pq_reg   <= pq_next;
            ap_reg   <= ap_next;
            an_reg   <= an_next;
            bp_reg   <= bp_next;
            bn_reg   <= bn_next;
            wa_reg   <= wa_next;
            wb_reg   <= wb_next;
            res_reg  <= res_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_data  = res_reg;

endmodule

// ===== design/rqi_skid.sv =====
module rqi_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    input  rqi_pkg::result_t up_data,
    output logic             up_ready,
    output logic             down_valid,
    input  logic             down_ready,
    output rqi_pkg::result_t down_data
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    rqi_pkg::result_t out_data_reg;
    rqi_pkg::result_t out_data_next;
    rqi_pkg::result_t skid_data_reg;
    rqi_pkg::result_t skid_data_next;
    logic             take;

    // The output register refills from the skid word first; a stalled word parks in the skid.
    always_comb
    begin
        take            = !out_valid_reg || down_ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take)
        begin
            out_valid_next  = skid_valid_reg || up_valid;
            out_data_next   = skid_valid_reg ? skid_data_reg : up_data;
            skid_valid_next = 1'b0;
        end
        else if (!skid_valid_reg && up_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = up_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign up_ready   = !skid_valid_reg;
    assign down_valid = out_valid_reg;
    assign down_data  = out_data_reg;

endmodule

// ===== design/ray_quad_intersect.sv =====
// Ray against parallelogram hit test.
// The quad (corner, edges, scaled normal, unit normal, plane offset, material) is
// loaded through the write port: cfg_we, cfg_index and cfg_data, one register per
// write. Write only while no ray is in flight; the block itself does not enforce this.
// Rays arrive on ray_in as valid/ready words; each accepted word yields exactly one
// result word on hit_out, in order. A miss reports every field as zero.
// Throughput is one ray per cycle while hit_out.ready does not stall the pipeline. The
// path to hit_out.valid runs through the divider for t, which resolves one quotient bit per
// stage over 32 stages, plus two stages of plane products, six stages for the
// bounds, hit point and planar coordinates, and the output register.
// Reset clears the configuration registers to zero and empties the pipeline.
// When the receiver holds hit_out.ready low, the output word holds and one more word
// parks in a skid register; ray_in.ready then drops and the whole pipeline freezes
// without losing or repeating a word until the output drains.
module ray_quad_intersect (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rqi_pkg::IDX_W-1:0]      cfg_index,
    input  logic [rqi_pkg::VEC_W-1:0]      cfg_data,
    rqi_ray_if.sink                        ray_in,
    rqi_hit_if.source                      hit_out
);

    logic [rqi_pkg::VEC_W-1:0]              corner_reg;
    logic [rqi_pkg::VEC_W-1:0]              edge_u_reg;
    logic [rqi_pkg::VEC_W-1:0]              edge_v_reg;
    logic [rqi_pkg::VEC_W-1:0]              scaled_n_reg;
    logic [rqi_pkg::VEC_W-1:0]              normal_reg;
    logic signed [rqi_pkg::SCALAR_BITS-1:0] offset_reg;
    logic [rqi_pkg::MAT_W-1:0]              material_reg;

    rqi_pkg::cfg_t    cfg;
    rqi_pkg::ray_t    ray;
    logic             en;
    logic             front_valid;
    rqi_pkg::front_t  front_data;
    logic             div_valid;
    rqi_pkg::div_t    div_data;
    logic             back_valid;
    rqi_pkg::result_t back_data;
    rqi_pkg::result_t res;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg   <= '0;
            edge_u_reg   <= '0;
            edge_v_reg   <= '0;
            scaled_n_reg <= '0;
            normal_reg   <= '0;
            offset_reg   <= '0;
            material_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rqi_pkg::REG_CORNER:   corner_reg   <= cfg_data;
                rqi_pkg::REG_EDGE_U:   edge_u_reg   <= cfg_data;
                rqi_pkg::REG_EDGE_V:   edge_v_reg   <= cfg_data;
                rqi_pkg::REG_SCALED_N: scaled_n_reg <= cfg_data;
                rqi_pkg::REG_NORMAL:   normal_reg   <= cfg_data;
                rqi_pkg::REG_OFFSET:   offset_reg   <= cfg_data[rqi_pkg::SCALAR_BITS-1:0];
                rqi_pkg::REG_MATERIAL: material_reg <= cfg_data[rqi_pkg::MAT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.corner   = corner_reg;
    assign cfg.edge_u   = edge_u_reg;
    assign cfg.edge_v   = edge_v_reg;
    assign cfg.scaled_n = scaled_n_reg;
    assign cfg.normal   = normal_reg;
    assign cfg.offset   = offset_reg;
    assign cfg.material = material_reg;

    // Input word and pipeline advance.
    assign ray.ray_origin    = ray_in.ray_origin;
    assign ray.ray_direction = ray_in.ray_direction;
    assign ray.t_min         = ray_in.t_min;
    assign ray.t_max         = ray_in.t_max;
    assign ray_in.ready      = en;

    rqi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ray_in.valid),
        .in_ray    (ray),
        .cfg       (cfg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    rqi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    rqi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .cfg       (cfg),
        .out_valid (back_valid),
        .out_data  (back_data)
    );

    rqi_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (back_valid),
        .up_data    (back_data),
        .up_ready   (en),
        .down_valid (hit_out.valid),
        .down_ready (hit_out.ready),
        .down_data  (res)
    );

    // Result word onto the output channel.
    assign hit_out.hit          = res.hit;
    assign hit_out.hit_t        = res.hit_t;
    assign hit_out.hit_point    = res.hit_point;
    assign hit_out.hit_normal   = res.hit_normal;
    assign hit_out.surface_u    = res.surface_u;
    assign hit_out.surface_v    = res.surface_v;
    assign hit_out.front_face   = res.front_face;
    assign hit_out.hit_material = res.hit_material;

endmodule
